FILE: design/mrxsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxsh_pkg
// Constants, command and status types shared by the stream hash modules.
// ----------------------------------------------------------------------------
package mrxsh_pkg;

   localparam int CHUNK_BYTES     = 32;
   localparam int WORD_BYTES      = 8;
   localparam int WORDS_PER_CHUNK = CHUNK_BYTES / WORD_BYTES;
   localparam int PENDING_DEPTH   = WORDS_PER_CHUNK - 1;

   localparam logic [1:0] LAST_CHUNK_WORD = 2'(WORDS_PER_CHUNK - 1);
   localparam logic [1:0] PENDING_FULL    = 2'(PENDING_DEPTH);
   localparam logic [3:0] FULL_WORD_BYTES = 4'(WORD_BYTES);

   localparam logic [31:0] KEY_LOW   = 32'h85EB_CA87;
   localparam logic [31:0] MUL_LOW   = 32'h9E37_79F9;
   localparam logic [63:0] TAIL_MUL  = 64'h9E37_79B1_85EB_CA87;
   localparam logic [63:0] AVAL_MUL1 = 64'hFF51_AFD7_ED55_8CCD;
   localparam logic [63:0] AVAL_MUL2 = 64'hC4CE_B9FE_1A85_EC53;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_PUSH,
      OP_FOLD_MUL,
      OP_FOLD_ACC,
      OP_H_INIT,
      OP_TAIL_XOR,
      OP_MUL_LL,
      OP_MUL_HL,
      OP_MUL_LH,
      OP_MUL_SUM,
      OP_AVAL_XOR,
      OP_EMIT
   } dp_op_type;

   // which step of the finish sequence is running; also picks the multiplier constant
   typedef enum logic [1:0] {
      PH_TAIL,
      PH_AV1,
      PH_AV2,
      PH_FIN
   } phase_type;

   typedef struct packed {
      dp_op_type  op;
      phase_type  phase;
      logic [1:0] word_idx;
      logic       use_cur;
      logic [2:0] byte_idx;
   } cmd_type;

   typedef struct packed {
      logic [1:0] pend_cnt;
      logic [3:0] vb;
      logic       last;
      logic       out_free;
   } status_type;

endpackage

FILE: design/mrxsh_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxsh_req_if
// Input channel: one message word per transaction.
// ----------------------------------------------------------------------------
interface mrxsh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] word;
   logic [3:0]  valid_bytes;
   logic        last;

   modport source (output valid, output word, output valid_bytes, output last,
                   input ready);
   modport sink   (input valid, input word, input valid_bytes, input last,
                   output ready);
endinterface

FILE: design/mrxsh_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxsh_rsp_if
// Result channel: one hash and length per message.
// ----------------------------------------------------------------------------
interface mrxsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   logic [31:0] byte_length;

   modport source (output valid, output hash_value, output byte_length,
                   input ready);
   modport sink   (input valid, input hash_value, input byte_length,
                   output ready);
endinterface

FILE: design/mrxsh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxsh_dp
// Hash datapath: word buffer, accumulator, shared 32x32 multiplier and the
// result register.
// ----------------------------------------------------------------------------
module mrxsh_dp
   import mrxsh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [63:0] in_word,
   input  logic [3:0]  in_valid_bytes,
   input  logic        in_last,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [63:0] out_hash_value,
   output logic [31:0] out_byte_length
);

   logic [63:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] len_ff, len_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [63:0] pend_ff [PENDING_DEPTH];
   logic [63:0] pend_in [PENDING_DEPTH];
   logic [63:0] word_ff, word_in;
   logic [3:0]  vb_ff, vb_in;
   logic        last_ff, last_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] cross_ff, cross_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] rsp_len_ff, rsp_len_in;

   logic [63:0] sel_word;
   logic [7:0]  sel_byte;
   logic [63:0] mul_k;
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic [3:0]  load_bytes;

   always_comb begin
      if (cmd.use_cur) begin
         sel_word = word_ff;
      end else begin
         case (cmd.word_idx)
            2'd0:    sel_word = pend_ff[0];
            2'd1:    sel_word = pend_ff[1];
            2'd2:    sel_word = pend_ff[2];
            default: sel_word = word_ff;
         endcase
      end
   end

   assign sel_byte = sel_word[{cmd.byte_idx, 3'b000} +: 8];

   always_comb begin
      case (cmd.phase)
         PH_AV1:  mul_k = AVAL_MUL1;
         PH_AV2:  mul_k = AVAL_MUL2;
         default: mul_k = TAIL_MUL;
      endcase
   end

   // one shared multiplier, operands picked by the current step
   always_comb begin
      case (cmd.op)
         OP_FOLD_MUL: begin
            mul_a = sel_word[31:0] ^ KEY_LOW;
            mul_b = MUL_LOW;
         end
         OP_MUL_HL: begin
            mul_a = h_ff[63:32];
            mul_b = mul_k[31:0];
         end
         OP_MUL_LH: begin
            mul_a = h_ff[31:0];
            mul_b = mul_k[63:32];
         end
         default: begin
            mul_a = h_ff[31:0];
            mul_b = mul_k[31:0];
         end
      endcase
   end

   assign product = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      if (!in_last) begin
         load_bytes = FULL_WORD_BYTES;
      end else if (in_valid_bytes > FULL_WORD_BYTES) begin
         load_bytes = FULL_WORD_BYTES;
      end else begin
         load_bytes = in_valid_bytes;
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      rsp_valid_in = rsp_valid_ff;
      pend_in      = pend_ff;
      word_in      = word_ff;
      vb_in        = vb_ff;
      last_in      = last_ff;
      h_in         = h_ff;
      prod_in      = prod_ff;
      cross_in     = cross_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_len_in   = rsp_len_ff;

      if (rsp_valid_ff && out_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd.op)
         OP_LOAD: begin
            word_in = in_word;
            vb_in   = load_bytes;
            last_in = in_last;
            len_in  = len_ff + 32'(load_bytes);
         end
         OP_PUSH: begin
            case (cnt_ff)
               2'd0:    pend_in[0] = word_ff;
               2'd1:    pend_in[1] = word_ff;
               default: pend_in[2] = word_ff;
            endcase
            cnt_in = cnt_ff + 2'd1;
         end
         OP_FOLD_MUL: begin
            prod_in = product;
         end
         OP_FOLD_ACC: begin
            // rotate left by 31
            acc_in = acc_ff ^ {prod_ff[32:0], prod_ff[63:33]};
            if (cmd.word_idx == LAST_CHUNK_WORD) begin
               cnt_in = 2'd0;
            end
         end
         OP_H_INIT: begin
            h_in = acc_ff;
         end
         OP_TAIL_XOR: begin
            h_in = h_ff ^ {56'd0, sel_byte};
         end
         OP_MUL_LL: begin
            prod_in = product;
         end
         OP_MUL_HL: begin
            cross_in = product[31:0];
         end
         OP_MUL_LH: begin
            cross_in = cross_ff + product[31:0];
         end
         OP_MUL_SUM: begin
            h_in = prod_ff + {cross_ff, 32'd0};
         end
         OP_AVAL_XOR: begin
            h_in = h_ff ^ {33'd0, h_ff[63:33]};
         end
         OP_EMIT: begin
            rsp_hash_in  = h_ff;
            rsp_len_in   = len_ff;
            rsp_valid_in = 1'b1;
            acc_in       = 64'd0;
            cnt_in       = 2'd0;
            len_in       = 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         cnt_ff       <= 2'd0;
         len_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      word_ff     <= word_in;
      vb_ff       <= vb_in;
      last_ff     <= last_in;
      h_ff        <= h_in;
      prod_ff     <= prod_in;
      cross_ff    <= cross_in;
      rsp_hash_ff <= rsp_hash_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign status.pend_cnt = cnt_ff;
   assign status.vb       = vb_ff;
   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || out_ready;

   assign out_valid       = rsp_valid_ff;
   assign out_hash_value  = rsp_hash_ff;
   assign out_byte_length = rsp_len_ff;

endmodule

FILE: design/mrxsh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrxsh_ctrl
// Sequencer: buffers words, folds complete chunks, walks the tail bytes and
// runs the avalanche through the shared multiplier.
// ----------------------------------------------------------------------------
module mrxsh_ctrl
   import mrxsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_DECIDE = 14'b00000000000010,
      ST_FMUL   = 14'b00000000000100,
      ST_FACC   = 14'b00000000001000,
      ST_AINIT  = 14'b00000000010000,
      ST_TINIT  = 14'b00000000100000,
      ST_TNEXT  = 14'b00000001000000,
      ST_TXOR   = 14'b00000010000000,
      ST_M0     = 14'b00000100000000,
      ST_M1     = 14'b00001000000000,
      ST_M2     = 14'b00010000000000,
      ST_M3     = 14'b00100000000000,
      ST_AXOR   = 14'b01000000000000,
      ST_RESULT = 14'b10000000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] widx_ff, widx_in;
   logic [3:0] bidx_ff, bidx_in;
   phase_type  phase_ff, phase_in;

   logic cur_word;

   // in the tail walk the word after the buffered ones is the final word
   assign cur_word = (widx_ff == status.pend_cnt);

   always_comb begin
      state_in     = state_ff;
      widx_in      = widx_ff;
      bidx_in      = bidx_ff;
      phase_in     = phase_ff;
      req_ready    = 1'b0;
      cmd.op       = OP_NOP;
      cmd.phase    = phase_ff;
      cmd.word_idx = widx_ff;
      cmd.use_cur  = cur_word;
      cmd.byte_idx = bidx_ff[2:0];

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            widx_in = 2'd0;
            bidx_in = 4'd0;
            if (!status.last) begin
               if (status.pend_cnt != PENDING_FULL) begin
                  cmd.op   = OP_PUSH;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FMUL;
               end
            end else if (status.pend_cnt == PENDING_FULL &&
                         status.vb == FULL_WORD_BYTES) begin
               state_in = ST_FMUL;
            end else begin
               state_in = ST_TINIT;
            end
         end
         ST_FMUL: begin
            cmd.op      = OP_FOLD_MUL;
            cmd.use_cur = (widx_ff == LAST_CHUNK_WORD);
            state_in    = ST_FACC;
         end
         ST_FACC: begin
            cmd.op = OP_FOLD_ACC;
            if (widx_ff == LAST_CHUNK_WORD) begin
               state_in = status.last ? ST_AINIT : ST_IDLE;
            end else begin
               widx_in  = widx_ff + 2'd1;
               state_in = ST_FMUL;
            end
         end
         ST_AINIT: begin
            cmd.op   = OP_H_INIT;
            phase_in = PH_AV1;
            state_in = ST_AXOR;
         end
         ST_TINIT: begin
            cmd.op   = OP_H_INIT;
            phase_in = PH_TAIL;
            state_in = ST_TNEXT;
         end
         ST_TNEXT: begin
            if (cur_word) begin
               if (bidx_ff == status.vb) begin
                  phase_in = PH_AV1;
                  state_in = ST_AXOR;
               end else begin
                  state_in = ST_TXOR;
               end
            end else if (bidx_ff == FULL_WORD_BYTES) begin
               widx_in = widx_ff + 2'd1;
               bidx_in = 4'd0;
            end else begin
               state_in = ST_TXOR;
            end
         end
         ST_TXOR: begin
            cmd.op   = OP_TAIL_XOR;
            state_in = ST_M0;
         end
         ST_M0: begin
            cmd.op   = OP_MUL_LL;
            state_in = ST_M1;
         end
         ST_M1: begin
            cmd.op   = OP_MUL_HL;
            state_in = ST_M2;
         end
         ST_M2: begin
            cmd.op   = OP_MUL_LH;
            state_in = ST_M3;
         end
         ST_M3: begin
            cmd.op = OP_MUL_SUM;
            case (phase_ff)
               PH_TAIL: begin
                  bidx_in  = bidx_ff + 4'd1;
                  state_in = ST_TNEXT;
               end
               PH_AV1: begin
                  phase_in = PH_AV2;
                  state_in = ST_AXOR;
               end
               default: begin
                  phase_in = PH_FIN;
                  state_in = ST_AXOR;
               end
            endcase
         end
         ST_AXOR: begin
            cmd.op   = OP_AVAL_XOR;
            state_in = (phase_ff == PH_FIN) ? ST_RESULT : ST_M0;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         widx_ff  <= 2'd0;
         bidx_ff  <= 4'd0;
         phase_ff <= PH_TAIL;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         bidx_ff  <= bidx_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: design/multiply_rotate_xor_stream_hash.sv
`timescale 1ns / 1ps
// A message streams in as 64-bit little-endian words, one per transaction,
// and one hash and byte length come out after the word marked last. The
// block takes one word at a time through a single shared 32x32 multiplier.
// A buffered word is stored; a word that completes a 32-byte chunk runs
// four fold multiplies, each followed by an accumulate. A final word that
// closes a chunk goes on to the avalanche; any other final word first walks
// its tail bytes (up to 31 tail bytes) with a multiply per byte. Every 64-bit
// multiply of the tail and avalanche is split into three 32x32
// partial products. The result waits in an output register, so
// the next message can start while it is still held; a later result that
// finds that register still full waits in its last step until it drains.
// ----------------------------------------------------------------------------
// multiply_rotate_xor_stream_hash
// Streaming multiply-rotate-xor hash, top level.
// ----------------------------------------------------------------------------
module multiply_rotate_xor_stream_hash
   import mrxsh_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   mrxsh_req_if.sink   req_bus,
   mrxsh_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   mrxsh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrxsh_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_word         (req_bus.word),
      .in_valid_bytes  (req_bus.valid_bytes),
      .in_last         (req_bus.last),
      .out_valid       (rsp_bus.valid),
      .out_ready       (rsp_bus.ready),
      .out_hash_value  (rsp_bus.hash_value),
      .out_byte_length (rsp_bus.byte_length)
   );

endmodule
